// ----- rtl/spo2_ratio_estimator_defines.svh -----
// Assertion macros used by the estimator's top-level RTL.
`ifndef SPO2_RATIO_ESTIMATOR_DEFINES_SVH
`define SPO2_RATIO_ESTIMATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPO2_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPO2_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/spo2_pkg.sv -----
`default_nettype none

package spo2_pkg;

  localparam int IN_W    = 18;
  localparam int EST_W   = 20;
  localparam int RATIO_W = 16;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 18;

  localparam logic [ADDR_W-1:0] REG_DC_ALPHA     = 3'd0;
  localparam logic [ADDR_W-1:0] REG_SPO2_ALPHA   = 3'd1;
  localparam logic [ADDR_W-1:0] REG_WINDOW_LEN   = 3'd2;
  localparam logic [ADDR_W-1:0] REG_THIN_INT     = 3'd3;
  localparam logic [ADDR_W-1:0] REG_FINGER_THR   = 3'd4;
  localparam logic [ADDR_W-1:0] REG_BOOT_HOLD    = 3'd5;

  localparam logic [5:0] MOD_STEPS  = 6'd10;
  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'd44;

  localparam logic signed [EST_W-1:0] EST_RESET  = 20'sd24320;
  localparam logic signed [EST_W-1:0] EST_FINGER = 20'sd20480;

  typedef struct packed {
    logic [15:0] dc_alpha;
    logic [15:0] spo2_alpha;
    logic [9:0]  window_len;
    logic [7:0]  thin_interval;
    logic [17:0] finger_threshold;
    logic [15:0] boot_hold_samples;
  } cfg_regs_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MOD_START, OP_MOD_STEP,
    OP_DC_MUL_RED, OP_DC_ADD_RED, OP_DC_MUL_IR, OP_DC_ADD_IR,
    OP_SQ_MUL_RED, OP_SQ_ADD_RED, OP_SQ_MUL_IR, OP_SQ_ADD_IR,
    OP_FINGER, OP_SQRT_START, OP_SQRT_STEP, OP_MUL_N, OP_MUL_M, OP_SCALE,
    OP_DIV_START, OP_DIV_STEP, OP_RATIO, OP_RAW_MUL, OP_RAW_DIV, OP_RAW_FIX,
    OP_LP_MUL, OP_LP_ADD, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic finger_hit;
    logic window_hit;
    logic scale_needed;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MOD_INIT, ST_MOD,
    ST_DCR_MUL, ST_DCR_ADD, ST_DCI_MUL, ST_DCI_ADD,
    ST_SQR_MUL, ST_SQR_ADD, ST_SQI_MUL, ST_SQI_ADD, ST_CHECK,
    ST_SQRT_INIT, ST_SQRT, ST_MUL_N, ST_MUL_M, ST_SCALE,
    ST_DIV_INIT, ST_DIV, ST_RATIO, ST_RAW_MUL, ST_RAW_DIV, ST_RAW_FIX,
    ST_LP_MUL, ST_LP_ADD, ST_EMIT
  } ctrl_state_t;

endpackage

`default_nettype wire

// ----- rtl/spo2_ifs.sv -----
`default_nettype none

interface spo2_in_if;
  import spo2_pkg::*;
  logic              valid;
  logic              ready;
  logic [IN_W-1:0]   red_sample;
  logic [IN_W-1:0]   ir_sample;
  modport source (output valid, red_sample, ir_sample, input ready);
  modport sink   (input valid, red_sample, ir_sample, output ready);
endinterface

interface spo2_out_if;
  import spo2_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [EST_W-1:0]  spo2_estimate;
  logic                     window_done;
  logic                     finger_off;
  logic [RATIO_W-1:0]       ratio_value;
  modport source (output valid, spo2_estimate, window_done, finger_off, ratio_value,
                  input ready);
  modport sink   (input valid, spo2_estimate, window_done, finger_off, ratio_value,
                  output ready);
endinterface

interface spo2_cfg_if;
  import spo2_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/spo2_isqrt.sv -----
`default_nettype none

module spo2_isqrt (
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic        step,
  input  wire logic [63:0] value,
  output logic      [31:0] root
);
  logic [63:0] rad;
  logic [33:0] rem;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        take;

  // Two radicand bits per step, one root bit per step.
  assign rem_sh = {rem[32:0], rad[63:62]};
  assign trial  = {1'b0, root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (load) begin
      rad  <= value;
      rem  <= '0;
      root <= '0;
    end else if (step) begin
      rad  <= {rad[61:0], 2'b00};
      rem  <= take ? 34'(rem_sh - trial) : 34'(rem_sh);
      root <= {root[30:0], take};
    end
  end
endmodule

`default_nettype wire

// ----- rtl/spo2_dp.sv -----
`default_nettype none

module spo2_dp #(
  parameter int SAMPLE_BITS = 18
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire spo2_pkg::dp_cmd_t    cmd,
  input  wire spo2_pkg::cfg_regs_t  cfg,
  input  wire logic [17:0]          red_in,
  input  wire logic [17:0]          ir_in,
  output spo2_pkg::dp_stat_t        stat,
  spo2_out_if.source                results
);
  import spo2_pkg::*;

  localparam int FRAC = 32 - SAMPLE_BITS;
  localparam logic [IN_W-1:0] SMASK =
    (SAMPLE_BITS >= IN_W) ? {IN_W{1'b1}} : IN_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [31:0] red_x, ir_x;
  logic [IN_W-1:0] ir_s;
  logic [9:0]  wc;
  logic [15:0] ssr;
  logic [7:0]  mod_rem;
  logic [9:0]  mod_sh;
  logic [31:0] red_dc, ir_dc;
  logic [63:0] red_sum, ir_sum;
  logic [63:0] prod;
  logic [63:0] n_val, m_val;
  logic [32:0] div_rem;
  logic [43:0] div_dq;
  logic [15:0] last_ratio;
  logic [21:0] raw_v;
  logic signed [17:0] raw;
  logic signed [36:0] lp_prod;
  logic signed [EST_W-1:0] est;
  logic off_flag, done_flag;
  logic out_valid;

  logic [7:0]  thin;
  logic [9:0]  wlen;
  logic [16:0] inv_a, inv_b;
  logic [8:0]  mod_sh_rem;
  logic [31:0] red_d, ir_d;
  logic [49:0] dc_sum_red, dc_sum_ir;
  logic [64:0] acc_red, acc_ir;
  logic [32:0] div_sh;
  logic        div_ge;
  logic [17:0] q0;
  logic [21:0] q_rem;
  logic [17:0] q_fix;
  logic signed [39:0] lp_t;
  logic signed [23:0] lp_e;
  logic [31:0] sqrt_red, sqrt_ir;
  logic sqrt_load, sqrt_step;

  assign thin  = (cfg.thin_interval == 8'd0) ? 8'd1 : cfg.thin_interval;
  assign wlen  = (cfg.window_len == 10'd0) ? 10'd1 : cfg.window_len;
  assign inv_a = 17'(18'd65536 - 18'(cfg.dc_alpha));
  assign inv_b = 17'(18'd65536 - 18'(cfg.spo2_alpha));

  assign mod_sh_rem = {mod_rem, mod_sh[9]};
  assign red_d = (red_x >= red_dc) ? red_x - red_dc : red_dc - red_x;
  assign ir_d  = (ir_x >= ir_dc) ? ir_x - ir_dc : ir_dc - ir_x;
  assign dc_sum_red = 50'(prod[47:0]) + 50'(red_x * inv_a) + 50'd32768;
  assign dc_sum_ir  = 50'(prod[47:0]) + 50'(ir_x * inv_a) + 50'd32768;
  assign acc_red = {1'b0, red_sum} + {1'b0, prod >> FRAC};
  assign acc_ir  = {1'b0, ir_sum} + {1'b0, prod >> FRAC};
  assign div_sh  = {div_rem[31:0], div_dq[43]};
  assign div_ge  = div_sh >= {1'b0, m_val[31:0]};
  assign q0      = prod[44:27];
  assign q_rem   = raw_v - 22'(q0 * 5'd25);
  assign q_fix   = q0 + ((q_rem >= 22'd25) ? 18'd1 : 18'd0);
  assign lp_t    = 40'(lp_prod) + 40'($signed({1'b0, inv_b}) * raw) + 40'sd32768;
  assign lp_e    = 24'(lp_t >>> 16);

  assign sqrt_load = cmd.op == OP_SQRT_START;
  assign sqrt_step = cmd.op == OP_SQRT_STEP;

  spo2_isqrt u_sqrt_red (
    .clk(clk), .load(sqrt_load), .step(sqrt_step), .value(red_sum), .root(sqrt_red)
  );
  spo2_isqrt u_sqrt_ir (
    .clk(clk), .load(sqrt_load), .step(sqrt_step), .value(ir_sum), .root(sqrt_ir)
  );

  always_comb begin
    stat.finger_hit   = (mod_rem == 8'd0) && (ssr > cfg.boot_hold_samples) &&
                        (ir_s < cfg.finger_threshold);
    stat.window_hit   = wc >= wlen;
    stat.scale_needed = (n_val[63:32] != 32'd0) || (m_val[63:32] != 32'd0);
    stat.out_free     = !out_valid || results.ready;
  end

  assign results.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wc <= '0;
      ssr <= '0;
      red_dc <= '0;
      ir_dc <= '0;
      red_sum <= '0;
      ir_sum <= '0;
      last_ratio <= '0;
      est <= EST_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          red_x <= 32'(64'(red_in & SMASK) << FRAC);
          ir_x  <= 32'(64'(ir_in & SMASK) << FRAC);
          ir_s  <= ir_in & SMASK;
          wc    <= wc + 10'd1;
          if (ssr != 16'hFFFF) begin
            ssr <= ssr + 16'd1;
          end
          off_flag  <= 1'b0;
          done_flag <= 1'b0;
        end
        OP_MOD_START: begin
          mod_rem <= '0;
          mod_sh  <= wc;
        end
        OP_MOD_STEP: begin
          mod_sh  <= {mod_sh[8:0], 1'b0};
          mod_rem <= (mod_sh_rem >= {1'b0, thin}) ? 8'(mod_sh_rem - {1'b0, thin})
                                                  : 8'(mod_sh_rem);
        end
        OP_DC_MUL_RED: prod <= 64'(red_dc * cfg.dc_alpha);
        OP_DC_ADD_RED: red_dc <= dc_sum_red[47:16];
        OP_DC_MUL_IR:  prod <= 64'(ir_dc * cfg.dc_alpha);
        OP_DC_ADD_IR:  ir_dc <= dc_sum_ir[47:16];
        OP_SQ_MUL_RED: prod <= red_d * red_d;
        OP_SQ_ADD_RED: red_sum <= acc_red[64] ? {64{1'b1}} : acc_red[63:0];
        OP_SQ_MUL_IR:  prod <= ir_d * ir_d;
        OP_SQ_ADD_IR:  ir_sum <= acc_ir[64] ? {64{1'b1}} : acc_ir[63:0];
        OP_FINGER: begin
          est      <= EST_FINGER;
          off_flag <= 1'b1;
        end
        OP_MUL_N: n_val <= sqrt_red * ir_dc;
        OP_MUL_M: m_val <= sqrt_ir * red_dc;
        OP_SCALE: begin
          n_val <= n_val >> 1;
          m_val <= m_val >> 1;
        end
        OP_DIV_START: begin
          div_rem <= '0;
          div_dq  <= {n_val[31:0], 12'd0};
        end
        OP_DIV_STEP: begin
          div_rem <= div_ge ? 33'(div_sh - {1'b0, m_val[31:0]}) : div_sh;
          div_dq  <= {div_dq[42:0], div_ge};
        end
        OP_RATIO: begin
          // A zero divisor or a quotient past 16 bits saturates the ratio.
          last_ratio <= ((m_val[31:0] == 32'd0) || (div_dq[43:16] != 28'd0)) ?
                        16'hFFFF : div_dq[15:0];
        end
        OP_RAW_MUL: raw_v <= 22'((27'd102389136 - 27'(last_ratio * 11'd1165)) >> 5);
        OP_RAW_DIV: prod <= 64'(raw_v * 23'd5368709);
        OP_RAW_FIX: raw <= $signed(q_fix - 18'd100000);
        OP_LP_MUL:  lp_prod <= $signed({1'b0, cfg.spo2_alpha}) * est;
        OP_LP_ADD: begin
          if (lp_e > 24'sd524287) begin
            est <= 20'sd524287;
          end else if (lp_e < -24'sd524288) begin
            est <= -20'sd524288;
          end else begin
            est <= 20'(lp_e);
          end
          red_sum   <= '0;
          ir_sum    <= '0;
          wc        <= '0;
          done_flag <= 1'b1;
        end
        OP_EMIT: begin
          results.spo2_estimate <= est;
          results.window_done   <= done_flag;
          results.finger_off    <= off_flag;
          results.ratio_value   <= last_ratio;
        end
        default: begin
        end
      endcase
    end
  end
endmodule

`default_nettype wire

// ----- rtl/spo2_ctrl.sv -----
`default_nettype none

module spo2_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire spo2_pkg::dp_stat_t stat,
  output spo2_pkg::dp_cmd_t       cmd
);
  import spo2_pkg::*;

  ctrl_state_t state, state_next;
  logic [5:0]  cnt;
  logic        last;

  always_comb begin
    case (state)
      ST_MOD:  last = cnt == MOD_STEPS - 6'd1;
      ST_SQRT: last = cnt == SQRT_STEPS - 6'd1;
      ST_DIV:  last = cnt == DIV_STEPS - 6'd1;
      default: last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= last ? 6'd0 : cnt + 6'd1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_MOD_INIT;
      ST_MOD_INIT:  state_next = ST_MOD;
      ST_MOD:       if (last) state_next = ST_DCR_MUL;
      ST_DCR_MUL:   state_next = ST_DCR_ADD;
      ST_DCR_ADD:   state_next = ST_DCI_MUL;
      ST_DCI_MUL:   state_next = ST_DCI_ADD;
      ST_DCI_ADD:   state_next = ST_SQR_MUL;
      ST_SQR_MUL:   state_next = ST_SQR_ADD;
      ST_SQR_ADD:   state_next = ST_SQI_MUL;
      ST_SQI_MUL:   state_next = ST_SQI_ADD;
      ST_SQI_ADD:   state_next = ST_CHECK;
      ST_CHECK:     state_next = stat.window_hit ? ST_SQRT_INIT : ST_EMIT;
      ST_SQRT_INIT: state_next = ST_SQRT;
      ST_SQRT:      if (last) state_next = ST_MUL_N;
      ST_MUL_N:     state_next = ST_MUL_M;
      ST_MUL_M:     state_next = ST_SCALE;
      ST_SCALE:     if (!stat.scale_needed) state_next = ST_DIV_INIT;
      ST_DIV_INIT:  state_next = ST_DIV;
      ST_DIV:       if (last) state_next = ST_RATIO;
      ST_RATIO:     state_next = ST_RAW_MUL;
      ST_RAW_MUL:   state_next = ST_RAW_DIV;
      ST_RAW_DIV:   state_next = ST_RAW_FIX;
      ST_RAW_FIX:   state_next = ST_LP_MUL;
      ST_LP_MUL:    state_next = ST_LP_ADD;
      ST_LP_ADD:    state_next = ST_EMIT;
      ST_EMIT:      if (stat.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_MOD_INIT:  cmd.op = OP_MOD_START;
      ST_MOD:       cmd.op = OP_MOD_STEP;
      ST_DCR_MUL:   cmd.op = OP_DC_MUL_RED;
      ST_DCR_ADD:   cmd.op = OP_DC_ADD_RED;
      ST_DCI_MUL:   cmd.op = OP_DC_MUL_IR;
      ST_DCI_ADD:   cmd.op = OP_DC_ADD_IR;
      ST_SQR_MUL:   cmd.op = OP_SQ_MUL_RED;
      ST_SQR_ADD:   cmd.op = OP_SQ_ADD_RED;
      ST_SQI_MUL:   cmd.op = OP_SQ_MUL_IR;
      ST_SQI_ADD:   cmd.op = OP_SQ_ADD_IR;
      ST_CHECK:     if (stat.finger_hit) cmd.op = OP_FINGER;
      ST_SQRT_INIT: cmd.op = OP_SQRT_START;
      ST_SQRT:      cmd.op = OP_SQRT_STEP;
      ST_MUL_N:     cmd.op = OP_MUL_N;
      ST_MUL_M:     cmd.op = OP_MUL_M;
      ST_SCALE:     if (stat.scale_needed) cmd.op = OP_SCALE;
      ST_DIV_INIT:  cmd.op = OP_DIV_START;
      ST_DIV:       cmd.op = OP_DIV_STEP;
      ST_RATIO:     cmd.op = OP_RATIO;
      ST_RAW_MUL:   cmd.op = OP_RAW_MUL;
      ST_RAW_DIV:   cmd.op = OP_RAW_DIV;
      ST_RAW_FIX:   cmd.op = OP_RAW_FIX;
      ST_LP_MUL:    cmd.op = OP_LP_MUL;
      ST_LP_ADD:    cmd.op = OP_LP_ADD;
      ST_EMIT:      if (stat.out_free) cmd.op = OP_EMIT;
      default:      cmd.op = OP_NONE;
    endcase
  end
endmodule

`default_nettype wire

// ----- rtl/spo2_ratio_estimator.sv -----
// Ratio-of-ratios SpO2 estimator.
// The samples channel takes one beat per optical sample pair (red, IR). The
// results channel returns exactly one beat per sample: the filtered estimate,
// the window and finger-off flags, and the last ratio. The cfg channel writes
// one register per beat; it is always ready and must only be used while idle.
// A sample that closes a window also runs two parallel digit-by-digit
// square roots, operand scaling and a bit-serial divider before its
// result beat. One item is in work at a time. The samples channel is
// ready again as soon as the result has moved to the output register, so
// the next sample can be taken while the result still waits. A stalled
// receiver holds the result register and the controller waits at its
// final step until the register frees.
// Reset clears the DC levels, sums and counters, loads the estimate with 95
// percent and the registers with their default values.
`default_nettype none
`include "spo2_ratio_estimator_defines.svh"

module spo2_ratio_estimator #(
  parameter int SAMPLE_BITS = 18
) (
  input  wire logic  clk,
  input  wire logic  rst,
  spo2_in_if.sink    samples,
  spo2_out_if.source results,
  spo2_cfg_if.sink   cfg
);
  import spo2_pkg::*;

  cfg_regs_t regs;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic      in_ready;

  // Each register write completes with its beat, so the port never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dc_alpha          <= 16'd62259;
      regs.spo2_alpha        <= 16'd45875;
      regs.window_len        <= 10'd100;
      regs.thin_interval     <= 8'd5;
      regs.finger_threshold  <= 18'd30000;
      regs.boot_hold_samples <= 16'd150;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_DC_ALPHA:   regs.dc_alpha          <= cfg.data[15:0];
        REG_SPO2_ALPHA: regs.spo2_alpha        <= cfg.data[15:0];
        REG_WINDOW_LEN: regs.window_len        <= cfg.data[9:0];
        REG_THIN_INT:   regs.thin_interval     <= cfg.data[7:0];
        REG_FINGER_THR: regs.finger_threshold  <= cfg.data[17:0];
        REG_BOOT_HOLD:  regs.boot_hold_samples <= cfg.data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign samples.ready = in_ready;

  // The controller sequences one sample through the shared datapath.
  spo2_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(samples.valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  spo2_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg(regs),
    .red_in(samples.red_sample), .ir_in(samples.ir_sample),
    .stat(stat), .results(results)
  );

  // A sample in work blocks the next one.
  `SPO2_ASSERT_NEXT(a_one_in_work, samples.valid && samples.ready, !samples.ready, "second sample taken while busy")
  // A finger-off result without a window update carries the forced 80 percent.
  `SPO2_ASSERT_SAME(a_finger_value, results.valid && results.finger_off && !results.window_done, results.spo2_estimate == 20'sd20480, "finger-off estimate not 80 percent")
  // A new result only appears at the end of an item's work.
  `SPO2_ASSERT_SAME(a_result_origin, $rose(results.valid), $past(!samples.ready), "result without sample in work")
endmodule

`default_nettype wire

// ----- tb/tb_spo2_ratio_estimator.sv -----
`timescale 1ns / 1ps

module tb_spo2_ratio_estimator;
  import spo2_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  spo2_in_if  samples_if ();
  spo2_out_if results_if ();
  spo2_cfg_if cfg_if ();

  spo2_ratio_estimator dut (
    .clk(clk),
    .rst(rst),
    .samples(samples_if.sink),
    .results(results_if.source),
    .cfg(cfg_if.sink)
  );

  // One sample pair waiting to be driven.
  typedef struct packed {
    logic [IN_W-1:0] red;
    logic [IN_W-1:0] ir;
  } sample_pair_t;

  // One predicted result beat.
  typedef struct packed {
    logic signed [EST_W-1:0] estimate;
    logic                    closed;
    logic                    off;
    logic [RATIO_W-1:0]      ratio;
  } spo2_result_t;

  sample_pair_t pending_samples[$];
  spo2_result_t expected_results[$];
  int unsigned  error_count = 0;
  int           sender_idle_pct = 0;
  int           receiver_idle_pct = 0;
  bit           sender_hold = 1'b0;

  // Predictor copy of the configuration registers.
  logic [15:0] p_dc_alpha;
  logic [15:0] p_spo2_alpha;
  logic [9:0]  p_window_len;
  logic [7:0]  p_thin_interval;
  logic [17:0] p_finger_threshold;
  logic [15:0] p_boot_hold;

  // Predictor copy of the block's state.
  logic [63:0] p_red_dc, p_ir_dc;
  logic [63:0] p_red_sum, p_ir_sum;
  logic [9:0]  p_count;
  logic [15:0] p_since_reset;
  logic [15:0] p_ratio;
  longint      p_estimate;

  localparam int FRAC = 32 - IN_W;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] dc_track(input logic [63:0] dc, input logic [63:0] s);
    logic [63:0] a;
    a = {48'd0, p_dc_alpha};
    return (dc * a + (s << FRAC) * (64'd65536 - a) + 64'd32768) >> 16;
  endfunction

  function automatic logic [63:0] square_accum(input logic [63:0] acc, input logic [63:0] s,
                                               input logic [63:0] dc);
    logic [63:0] x, d, sq, r;
    x = s << FRAC;
    d = (x >= dc) ? x - dc : dc - x;
    sq = (d * d) >> FRAC;
    r = acc + sq;
    return (r < acc) ? 64'hFFFF_FFFF_FFFF_FFFF : r;
  endfunction

  function automatic logic [15:0] ratio_of_ratios();
    logic [63:0] n, m, q;
    n = int_sqrt(p_red_sum) * p_ir_dc;
    m = int_sqrt(p_ir_sum) * p_red_dc;
    while ((n >> 32) != 0 || (m >> 32) != 0) begin
      n = n >> 1;
      m = m >> 1;
    end
    if (m == 0) return 16'hFFFF;
    q = (n << 12) / m;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic longint mapped_spo2(input logic [15:0] r);
    longint num;
    num = 64'sd22388736 - 64'sd1165 * longint'(r) + 400 + 80000000;
    return num / 800 - 100000;
  endfunction

  function automatic longint smooth_spo2(input longint est, input longint raw);
    longint b, t, e;
    b = longint'(p_spo2_alpha);
    t = b * est + (65536 - b) * raw + 32768 + (64'sd1 << 36);
    e = (t >>> 16) - (64'sd1 << 20);
    if (e > 524287) e = 524287;
    if (e < -524288) e = -524288;
    return e;
  endfunction

  task automatic predictor_reset();
    p_dc_alpha = 16'd62259;
    p_spo2_alpha = 16'd45875;
    p_window_len = 10'd100;
    p_thin_interval = 8'd5;
    p_finger_threshold = 18'd30000;
    p_boot_hold = 16'd150;
    p_red_dc = 0;
    p_ir_dc = 0;
    p_red_sum = 0;
    p_ir_sum = 0;
    p_count = 0;
    p_since_reset = 0;
    p_ratio = 0;
    p_estimate = 24320;
  endtask

  // Runs one sample pair through the predictor and queues its result.
  task automatic predict_sample(input sample_pair_t sp);
    logic [63:0]  red, ir;
    logic [9:0]   thin, wlen;
    spo2_result_t res;
    red = {46'd0, sp.red};
    ir = {46'd0, sp.ir};
    thin = (p_thin_interval == 0) ? 10'd1 : {2'd0, p_thin_interval};
    wlen = (p_window_len == 0) ? 10'd1 : p_window_len;
    res.closed = 1'b0;
    res.off = 1'b0;
    p_count = p_count + 10'd1;
    if (p_since_reset != 16'hFFFF) p_since_reset = p_since_reset + 16'd1;
    p_red_dc = dc_track(p_red_dc, red);
    p_ir_dc = dc_track(p_ir_dc, ir);
    p_red_sum = square_accum(p_red_sum, red, p_red_dc);
    p_ir_sum = square_accum(p_ir_sum, ir, p_ir_dc);
    // The finger check comes before the window update of the same sample.
    if ((p_count % thin) == 0 && p_since_reset > p_boot_hold &&
        sp.ir < p_finger_threshold) begin
      p_estimate = 20480;
      res.off = 1'b1;
    end
    if (p_count >= wlen) begin
      p_ratio = ratio_of_ratios();
      p_estimate = smooth_spo2(p_estimate, mapped_spo2(p_ratio));
      p_red_sum = 0;
      p_ir_sum = 0;
      p_count = 0;
      res.closed = 1'b1;
    end
    res.estimate = p_estimate[EST_W-1:0];
    res.ratio = p_ratio;
    expected_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Driver: pops the queue and offers one beat at a time. A beat stays up
  // until it is taken, so valid is never lowered and raised in one step.
  always @(posedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
      samples_if.red_sample <= '0;
      samples_if.ir_sample <= '0;
    end else if (!samples_if.valid || samples_if.ready) begin
      if (samples_if.valid) predict_sample({samples_if.red_sample, samples_if.ir_sample});
      if (pending_samples.size() > 0 && !sender_hold &&
          $urandom_range(99, 0) >= sender_idle_pct) begin
        sample_pair_t sp;
        sp = pending_samples.pop_front();
        samples_if.valid <= 1'b1;
        samples_if.red_sample <= sp.red;
        samples_if.ir_sample <= sp.ir;
      end else begin
        samples_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every result beat against the oldest prediction and
  // stalls the receiver at random.
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("result beat with nothing expected at %0t", $time);
          error_count++;
        end else begin
          spo2_result_t want;
          want = expected_results.pop_front();
          if (results_if.spo2_estimate !== want.estimate)
            report_mismatch("spo2_estimate", results_if.spo2_estimate, want.estimate);
          if (results_if.window_done !== want.closed)
            report_mismatch("window_done", results_if.window_done, want.closed);
          if (results_if.finger_off !== want.off)
            report_mismatch("finger_off", results_if.finger_off, want.off);
          if (results_if.ratio_value !== want.ratio)
            report_mismatch("ratio_value", results_if.ratio_value, want.ratio);
        end
      end
      results_if.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
    end
  end

  // Waits until the driver has emptied its queue and every result came back.
  task automatic drain();
    while (pending_samples.size() > 0 || samples_if.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Each write lowers valid after its beat is taken and updates the
  // predictor copy before the next write starts.
  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.addr <= idx;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_DC_ALPHA:   p_dc_alpha = value[15:0];
      REG_SPO2_ALPHA: p_spo2_alpha = value[15:0];
      REG_WINDOW_LEN: p_window_len = value[9:0];
      REG_THIN_INT:   p_thin_interval = value[7:0];
      REG_FINGER_THR: p_finger_threshold = value[17:0];
      REG_BOOT_HOLD:  p_boot_hold = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] dca, input logic [15:0] spa,
                           input logic [9:0] wl, input logic [7:0] ti,
                           input logic [17:0] ft, input logic [15:0] bh);
    write_reg(REG_DC_ALPHA, 18'(dca));
    write_reg(REG_SPO2_ALPHA, 18'(spa));
    write_reg(REG_WINDOW_LEN, 18'(wl));
    write_reg(REG_THIN_INT, 18'(ti));
    write_reg(REG_FINGER_THR, ft);
    write_reg(REG_BOOT_HOLD, 18'(bh));
  endtask

  function automatic sample_pair_t pair(input logic [IN_W-1:0] r, input logic [IN_W-1:0] i);
    pair.red = r;
    pair.ir = i;
  endfunction

  // A pulse-like pair: DC level with a modest AC swing, or pure noise now
  // and then, or an IR level that dips under the finger threshold.
  function automatic sample_pair_t random_pair();
    int unsigned kind;
    logic [IN_W-1:0] base_r, base_i;
    kind = $urandom_range(99, 0);
    if (kind < 10) return pair(18'($urandom), 18'($urandom));
    if (kind < 20) return pair(18'($urandom_range(262143, 0)), 18'($urandom_range(40000, 0)));
    base_r = 18'($urandom_range(200000, 20000));
    base_i = 18'($urandom_range(200000, 20000));
    return pair(18'(base_r + $urandom_range(8000, 0)), 18'(base_i + $urandom_range(8000, 0)));
  endfunction

  task automatic queue_random(input int count);
    repeat (count) pending_samples.push_back(random_pair());
  endtask

  initial begin
    samples_if.valid = 1'b0;
    samples_if.red_sample = '0;
    samples_if.ir_sample = '0;
    results_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.data = '0;
    predictor_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: short windows with finger checks on every sample,
    // field extremes, and a zero window length so every sample closes a
    // window.
    write_all(16'd62259, 16'd45875, 10'd3, 8'd0, 18'd30000, 16'd0);
    pending_samples.push_back(pair(18'h3FFFF, 18'h3FFFF));
    pending_samples.push_back(pair(18'h00000, 18'h00000));
    pending_samples.push_back(pair(18'h3FFFF, 18'h00000));
    pending_samples.push_back(pair(18'h00000, 18'h3FFFF));
    pending_samples.push_back(pair(18'h2AAAA, 18'h15555));
    pending_samples.push_back(pair(18'h15555, 18'h2AAAA));
    pending_samples.push_back(pair(18'd100000, 18'd29999));
    pending_samples.push_back(pair(18'd100000, 18'd30000));
    pending_samples.push_back(pair(18'd100000, 18'd30001));
    drain();
    write_all(16'd0, 16'd0, 10'd0, 8'd1, 18'h3FFFF, 16'd65535);
    repeat (5) pending_samples.push_back(pair(18'($urandom), 18'($urandom)));
    drain();
    write_all(16'hFFFF, 16'hFFFF, 10'd1023, 8'd255, 18'd0, 16'd0);
    repeat (6) pending_samples.push_back(pair(18'($urandom), 18'($urandom)));
    drain();
    // Lowering the window length mid-window closes it on the next sample.
    write_reg(REG_WINDOW_LEN, 18'd2);
    pending_samples.push_back(pair(18'd50000, 18'd60000));
    drain();
    write_reg(3'd7, 18'h3FFFF);

    // Random part in three pressure phases.
    sender_idle_pct = 25;
    receiver_idle_pct = 77;
    write_all(16'd62259, 16'd45875, 10'd8, 8'd5, 18'd30000, 16'd20);
    queue_random(400);
    drain();
    sender_idle_pct = 77;
    receiver_idle_pct = 25;
    write_all(16'($urandom), 16'($urandom), 10'($urandom_range(12, 1)),
              8'($urandom_range(7, 1)), 18'($urandom_range(60000, 0)),
              16'($urandom_range(30, 0)));
    queue_random(200);
    // The sender holds back until the block has returned everything.
    while (pending_samples.size() > 0 || samples_if.valid) @(posedge clk);
    sender_hold = 1'b1;
    while (expected_results.size() > 0) @(posedge clk);
    sender_hold = 1'b0;
    queue_random(200);
    drain();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_all(16'd32768, 16'd1, 10'd1, 8'd2, 18'd100000, 16'd65534);
    queue_random(200);
    drain();
    write_all(16'd60000, 16'd50000, 10'd100, 8'd3, 18'd40000, 16'd0);
    queue_random(300);
    drain();

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // The timeout covers a run of about 1350 samples plus stalls.
  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

endmodule
